// ----- rtl/pvr_pkg.sv -----
// Package for the polygon vertex reducer.
// Holds the configuration register indexes and the stage control struct.
// No dependencies.
package pvr_pkg;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AXIS_X  = 2'd0,
      CSR_AXIS_Y  = 2'd1,
      CSR_QUERY_X = 2'd2,
      CSR_QUERY_Y = 2'd3
   } csr_index_type;

   // Control that travels with one vertex from stage to stage.
   typedef struct packed {
      logic valid;
      logic last;
   } pvr_ctl_type;

endpackage

// ----- rtl/pvr_products.sv -----
// Front of the polygon vertex reducer: input register and product stage.
// Forms the axis products and the squared offsets to the query point.
// Depends on pvr_pkg.
module pvr_products #(
   parameter int COORD_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [COORD_BITS-1:0]   in_x,
   input  logic signed [COORD_BITS-1:0]   in_y,
   input  logic                           in_last,
   input  logic signed [COORD_BITS-1:0]   axis_x,
   input  logic signed [COORD_BITS-1:0]   axis_y,
   input  logic signed [COORD_BITS-1:0]   query_x,
   input  logic signed [COORD_BITS-1:0]   query_y,
   output pvr_pkg::pvr_ctl_type           out_ctl,
   input  logic                           out_ready,
   output logic signed [COORD_BITS-1:0]   out_x,
   output logic signed [COORD_BITS-1:0]   out_y,
   output logic signed [2*COORD_BITS-1:0] out_prod_x,
   output logic signed [2*COORD_BITS-1:0] out_prod_y,
   output logic [2*COORD_BITS-1:0]        out_sq_x,
   output logic [2*COORD_BITS-1:0]        out_sq_y
);
   import pvr_pkg::*;

   pvr_ctl_type                    s1_ctl_ff, s1_ctl_in;
   logic signed [COORD_BITS-1:0]   s1_x_ff, s1_y_ff;
   logic [COORD_BITS-1:0]          s1_dx_ff, s1_dy_ff;
   logic [COORD_BITS-1:0]          dx_in, dy_in;
   logic signed [COORD_BITS:0]     diff_x, diff_y;

   pvr_ctl_type                    s2_ctl_ff, s2_ctl_in;
   logic signed [COORD_BITS-1:0]   s2_x_ff, s2_y_ff;
   logic signed [2*COORD_BITS-1:0] s2_prod_x_ff, s2_prod_y_ff;
   logic signed [2*COORD_BITS-1:0] prod_x_in, prod_y_in;
   logic [2*COORD_BITS-1:0]        s2_sq_x_ff, s2_sq_y_ff;
   logic [2*COORD_BITS-1:0]        sq_x_in, sq_y_in;

   logic s1_ready, s2_ready, s1_load, s2_load;

   assign s2_ready = !s2_ctl_ff.valid || out_ready;
   assign s1_ready = !s1_ctl_ff.valid || s2_ready;
   assign in_ready = s1_ready;
   assign s1_load  = in_valid && s1_ready;
   assign s2_load  = s1_ctl_ff.valid && s2_ready;

   // The magnitude of a coordinate difference stays below 2**COORD_BITS.
   always_comb begin
      diff_x = $signed({query_x[COORD_BITS-1], query_x}) - $signed({in_x[COORD_BITS-1], in_x});
      diff_y = $signed({query_y[COORD_BITS-1], query_y}) - $signed({in_y[COORD_BITS-1], in_y});
      dx_in  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
      dy_in  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
   end

   always_comb begin
      s1_ctl_in.valid = s1_load || (s1_ctl_ff.valid && !s2_ready);
      s1_ctl_in.last  = s1_load ? in_last : s1_ctl_ff.last;
      s2_ctl_in.valid = s2_load || (s2_ctl_ff.valid && !out_ready);
      s2_ctl_in.last  = s2_load ? s1_ctl_ff.last : s2_ctl_ff.last;
      prod_x_in       = (2*COORD_BITS)'(s1_x_ff) * (2*COORD_BITS)'(axis_x);
      prod_y_in       = (2*COORD_BITS)'(s1_y_ff) * (2*COORD_BITS)'(axis_y);
      sq_x_in         = (2*COORD_BITS)'(s1_dx_ff) * (2*COORD_BITS)'(s1_dx_ff);
      sq_y_in         = (2*COORD_BITS)'(s1_dy_ff) * (2*COORD_BITS)'(s1_dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
      end
      if (s1_load) begin
         s1_x_ff  <= in_x;
         s1_y_ff  <= in_y;
         s1_dx_ff <= dx_in;
         s1_dy_ff <= dy_in;
      end
      if (s2_load) begin
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_prod_x_ff <= prod_x_in;
         s2_prod_y_ff <= prod_y_in;
         s2_sq_x_ff   <= sq_x_in;
         s2_sq_y_ff   <= sq_y_in;
      end
   end

   assign out_ctl    = s2_ctl_ff;
   assign out_x      = s2_x_ff;
   assign out_y      = s2_y_ff;
   assign out_prod_x = s2_prod_x_ff;
   assign out_prod_y = s2_prod_y_ff;
   assign out_sq_x   = s2_sq_x_ff;
   assign out_sq_y   = s2_sq_y_ff;

endmodule

// ----- rtl/pvr_reduce.sv -----
// Reduction stage of the polygon vertex reducer: running min, max, box and
// nearest vertex, plus the result register. Depends on pvr_pkg.
module pvr_reduce #(
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pvr_pkg::pvr_ctl_type                  in_ctl,
   output logic                                  in_ready,
   input  logic signed [COORD_BITS-1:0]          in_x,
   input  logic signed [COORD_BITS-1:0]          in_y,
   input  logic signed [2*COORD_BITS-1:0]        in_prod_x,
   input  logic signed [2*COORD_BITS-1:0]        in_prod_y,
   input  logic [2*COORD_BITS-1:0]               in_sq_x,
   input  logic [2*COORD_BITS-1:0]               in_sq_y,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((12*COORD_BITS+4+7)/8)*8-1:0]  rsp_tdata
);
   import pvr_pkg::*;

   localparam int PROJ_BITS      = 2*COORD_BITS + 1;
   localparam int DIST_BITS      = 2*COORD_BITS + 2;
   localparam int RSP_FIELD_BITS = 2*PROJ_BITS + 6*COORD_BITS + DIST_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   logic signed [PROJ_BITS-1:0]  proj;
   logic [DIST_BITS-1:0]         dist_sq;

   logic signed [PROJ_BITS-1:0]  proj_min_ff, proj_min_in, proj_max_ff, proj_max_in;
   logic signed [COORD_BITS-1:0] x_min_ff, x_min_in, x_max_ff, x_max_in;
   logic signed [COORD_BITS-1:0] y_min_ff, y_min_in, y_max_ff, y_max_in;
   logic signed [COORD_BITS-1:0] near_x_ff, near_x_in, near_y_ff, near_y_in;
   logic [DIST_BITS-1:0]         near_dist_ff, near_dist_in;
   logic                         at_first_ff;
   logic                         rsp_tvalid_ff;
   logic [RSP_DATA_BITS-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                         out_free, take, take_last;

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign in_ready  = !in_ctl.last || out_free;
   assign take      = in_ctl.valid && in_ready;
   assign take_last = take && in_ctl.last;

   always_comb begin
      proj = $signed({in_prod_x[2*COORD_BITS-1], in_prod_x})
           + $signed({in_prod_y[2*COORD_BITS-1], in_prod_y});
      dist_sq = {2'b00, in_sq_x} + {2'b00, in_sq_y};

      if (at_first_ff) begin
         proj_min_in  = proj;
         proj_max_in  = proj;
         x_min_in     = in_x;
         x_max_in     = in_x;
         y_min_in     = in_y;
         y_max_in     = in_y;
         near_x_in    = in_x;
         near_y_in    = in_y;
         near_dist_in = dist_sq;
      end else begin
         proj_min_in  = (proj < proj_min_ff) ? proj : proj_min_ff;
         proj_max_in  = (proj > proj_max_ff) ? proj : proj_max_ff;
         x_min_in     = (in_x < x_min_ff) ? in_x : x_min_ff;
         x_max_in     = (in_x > x_max_ff) ? in_x : x_max_ff;
         y_min_in     = (in_y < y_min_ff) ? in_y : y_min_ff;
         y_max_in     = (in_y > y_max_ff) ? in_y : y_max_ff;
         // Only a strictly nearer vertex replaces the kept one.
         if (dist_sq < near_dist_ff) begin
            near_x_in    = in_x;
            near_y_in    = in_y;
            near_dist_in = dist_sq;
         end else begin
            near_x_in    = near_x_ff;
            near_y_in    = near_y_ff;
            near_dist_in = near_dist_ff;
         end
      end

      rsp_tdata_in = '0;
      rsp_tdata_in[RSP_FIELD_BITS-1:0] = {near_dist_in, near_y_in, near_x_in,
                                          y_max_in, y_min_in, x_max_in, x_min_in,
                                          proj_max_in, proj_min_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_first_ff   <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (take) begin
            at_first_ff <= in_ctl.last;
         end
         if (take_last) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
      if (take) begin
         proj_min_ff  <= proj_min_in;
         proj_max_ff  <= proj_max_in;
         x_min_ff     <= x_min_in;
         x_max_ff     <= x_max_in;
         y_min_ff     <= y_min_in;
         y_max_ff     <= y_max_in;
         near_x_ff    <= near_x_in;
         near_y_ff    <= near_y_in;
         near_dist_ff <= near_dist_in;
      end
      if (take_last) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      take_last |=> rsp_tvalid_ff) else $error("final vertex did not produce a result");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      take_last |=> at_first_ff) else $error("running state not cleared after final vertex");

   a_proj_order: assert property (@(posedge clock) disable iff (reset)
      !at_first_ff |-> proj_min_ff <= proj_max_ff) else $error("projection min above max");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      !at_first_ff |-> (x_min_ff <= x_max_ff) && (y_min_ff <= y_max_ff))
      else $error("bounding box inverted");

endmodule

// ----- rtl/polygon_vertex_reducer_top.sv -----
// Top level of the polygon vertex reducer: configuration registers and the
// two pipeline parts. Depends on pvr_pkg, pvr_products and pvr_reduce.
// Result path: the final vertex passes the input register and the product register, then the
// reduction writes the result register, which drives rsp_tvalid.
// Throughput: one vertex per cycle unless a final vertex stalls; the compares are combinational.
// The result register lets new vertices enter while a result waits to be taken.
// Reset: synchronous; clears the pipeline, arms the next vertex as a polygon's first,
// and sets axis to (256, 0) and the query point to (0, 0).
module polygon_vertex_reducer_top #(
   parameter int COORD_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: vertex_x, vertex_y.
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: proj_min, proj_max, box_x_min, box_x_max, box_y_min,
   // box_y_max, nearest_x, nearest_y, nearest_dist_sq.
   output logic [((12*COORD_BITS+4+7)/8)*8-1:0] rsp_tdata,
   input  logic                                 csr_we,
   input  logic [pvr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                csr_wdata
);
   import pvr_pkg::*;

   localparam logic signed [COORD_BITS-1:0] AXIS_X_RESET = COORD_BITS'(256);

   logic signed [COORD_BITS-1:0]   axis_x_ff, axis_y_ff, query_x_ff, query_y_ff;
   pvr_ctl_type                    mid_ctl;
   logic                           mid_ready;
   logic signed [COORD_BITS-1:0]   mid_x, mid_y;
   logic signed [2*COORD_BITS-1:0] mid_prod_x, mid_prod_y;
   logic [2*COORD_BITS-1:0]        mid_sq_x, mid_sq_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff  <= AXIS_X_RESET;
         axis_y_ff  <= '0;
         query_x_ff <= '0;
         query_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AXIS_X:  axis_x_ff  <= csr_wdata;
            CSR_AXIS_Y:  axis_y_ff  <= csr_wdata;
            CSR_QUERY_X: query_x_ff <= csr_wdata;
            CSR_QUERY_Y: query_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pvr_products #(
      .COORD_BITS (COORD_BITS)
   ) u_products (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_x       (req_tdata[COORD_BITS-1:0]),
      .in_y       (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .in_last    (req_tlast),
      .axis_x     (axis_x_ff),
      .axis_y     (axis_y_ff),
      .query_x    (query_x_ff),
      .query_y    (query_y_ff),
      .out_ctl    (mid_ctl),
      .out_ready  (mid_ready),
      .out_x      (mid_x),
      .out_y      (mid_y),
      .out_prod_x (mid_prod_x),
      .out_prod_y (mid_prod_y),
      .out_sq_x   (mid_sq_x),
      .out_sq_y   (mid_sq_y)
   );

   pvr_reduce #(
      .COORD_BITS (COORD_BITS)
   ) u_reduce (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (mid_ctl),
      .in_ready   (mid_ready),
      .in_x       (mid_x),
      .in_y       (mid_y),
      .in_prod_x  (mid_prod_x),
      .in_prod_y  (mid_prod_y),
      .in_sq_x    (mid_sq_x),
      .in_sq_y    (mid_sq_y),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
